FILE: hdl/bfi_pkg.sv
// ----------------------------------------------------------------------------
// bfi_pkg
// shared types, codes and widths of the bf interpreter core
// ----------------------------------------------------------------------------
package bfi_pkg;

  // default sizes of the stores
  localparam int PROGRAM_DEPTH_DEF = 1024;
  localparam int TAPE_CELLS_DEF    = 1024;
  localparam int INPUT_DEPTH_DEF   = 256;
  localparam int OUTPUT_DEPTH_DEF  = 256;

  // transaction field widths
  localparam int KIND_W    = 3;
  localparam int ADDR_W    = 10;
  localparam int BYTE_W    = 8;
  localparam int BUDGET_W  = 24;
  localparam int INLEN_W   = 9;
  localparam int COUNT_W   = 9;
  localparam int CONSUME_W = 16;
  localparam int PLEN_W    = 11;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-1:0] REG_PROGRAM_LENGTH = 3'd0;

  localparam logic [CONSUME_W-1:0] CONSUME_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_PROG = 3'd0,
    KIND_LOAD_IN   = 3'd1,
    KIND_RUN       = 3'd2,
    KIND_READ      = 3'd3,
    KIND_CLEAR     = 3'd4
  } kind_t;

  // command bytes
  localparam logic [BYTE_W-1:0] OP_INC   = 8'h2B;
  localparam logic [BYTE_W-1:0] OP_DEC   = 8'h2D;
  localparam logic [BYTE_W-1:0] OP_RIGHT = 8'h3E;
  localparam logic [BYTE_W-1:0] OP_LEFT  = 8'h3C;
  localparam logic [BYTE_W-1:0] OP_OUT   = 8'h2E;
  localparam logic [BYTE_W-1:0] OP_IN    = 8'h2C;
  localparam logic [BYTE_W-1:0] OP_OPEN  = 8'h5B;
  localparam logic [BYTE_W-1:0] OP_CLOSE = 8'h5D;
  localparam logic [BYTE_W-1:0] IN_EOF   = 8'h04;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_OUT_RD,
    ST_DONE
  } state_t;

  // control broadcast along the tape
  typedef struct packed {
    logic              clr;
    logic              up;    // each cell takes its upper neighbor (head moves right)
    logic              dn;    // each cell takes its lower neighbor (head moves left)
    logic              wr;
    logic [BYTE_W-1:0] wdata;
  } tape_ctrl_t;

endpackage

FILE: hdl/bfi_if.sv
// ----------------------------------------------------------------------------
// bfi_if
// valid/ready channels of the bf interpreter core
// ----------------------------------------------------------------------------
interface bfi_in_if;
  import bfi_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [ADDR_W-1:0]   address;
  logic [BYTE_W-1:0]   data;
  logic [BUDGET_W-1:0] step_budget;
  logic [INLEN_W-1:0]  input_length;

  modport source (output valid, kind, address, data, step_budget, input_length,
                  input ready);
  modport sink   (input valid, kind, address, data, step_budget, input_length,
                  output ready);
endinterface

interface bfi_out_if;
  import bfi_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [BYTE_W-1:0]    read_byte;
  logic [COUNT_W-1:0]   output_count;
  logic [CONSUME_W-1:0] inputs_consumed;
  logic [BUDGET_W-1:0]  steps_used;
  logic                 budget_exhausted;
  logic                 output_overflow;

  modport source (output valid, read_byte, output_count, inputs_consumed, steps_used,
                  budget_exhausted, output_overflow, input ready);
  modport sink   (input valid, read_byte, output_count, inputs_consumed, steps_used,
                  budget_exhausted, output_overflow, output ready);
endinterface

FILE: hdl/bfi_ram.sv
// ----------------------------------------------------------------------------
// bfi_ram
// single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module bfi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/bfi_cell.sv
// ----------------------------------------------------------------------------
// bfi_cell
// one tape cell: holds a byte, takes a neighbor's byte when the head moves
// ----------------------------------------------------------------------------
module bfi_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bfi_pkg::tape_ctrl_t        ctrl,
  input  logic [bfi_pkg::BYTE_W-1:0] from_up,
  input  logic [bfi_pkg::BYTE_W-1:0] from_dn,
  output logic [bfi_pkg::BYTE_W-1:0] data_o
);
  import bfi_pkg::*;

  logic [BYTE_W-1:0] data_r, data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.clr) begin
      data_nxt = '0;
    end else if (ctrl.up) begin
      data_nxt = from_up;
    end else if (ctrl.dn) begin
      data_nxt = from_dn;
    end else if (ctrl.wr) begin
      data_nxt = ctrl.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign data_o = data_r;
endmodule

FILE: hdl/bf_interpreter_core_top.sv
// ----------------------------------------------------------------------------
// bf_interpreter_core_top
// bf machine: program, input and output buffers in ram, tape as a ring of cells
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    carries
//  in_ch     in   valid/ready                  kind, address, data, budget, input length
//  out_ch    out  valid/ready                  one status transaction per input
//  cfg_*     in   apb write/read, pready = 1   program_length at byte address 0
//
//  load, clear and unknown transactions load their status straight from idle;
//  a read goes through out_rd and done; a run does fetch and exec per executed
//  step, scan_rd and scan_chk per byte walked while looking for a matching
//  bracket (ending on scan_rd when the walk runs off the program end), then
//  done; the program ram read port is shared by fetch and bracket search
//  the tape is a ring of cells that rotates so the head cell is always cell 0
//  reset clears the tape, status counters and flags directly; no clearing pass
//  a finished status waits in the output register; a new transaction is taken
//  only while that register is empty or being drained
// ----------------------------------------------------------------------------
module bf_interpreter_core_top #(
  parameter int PROGRAM_DEPTH = bfi_pkg::PROGRAM_DEPTH_DEF,
  parameter int TAPE_CELLS    = bfi_pkg::TAPE_CELLS_DEF,
  parameter int INPUT_DEPTH   = bfi_pkg::INPUT_DEPTH_DEF,
  parameter int OUTPUT_DEPTH  = bfi_pkg::OUTPUT_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  bfi_in_if.sink                     in_ch,
  bfi_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [bfi_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [bfi_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [bfi_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import bfi_pkg::*;

  // ram address widths and counter widths (counters can hold the depth itself)
  localparam int PAW = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
  localparam int PCW = $clog2(PROGRAM_DEPTH + 1);
  localparam int IAW = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;
  localparam int ICW = $clog2(INPUT_DEPTH + 1);
  localparam int OAW = (OUTPUT_DEPTH > 1) ? $clog2(OUTPUT_DEPTH) : 1;
  localparam int OCW = $clog2(OUTPUT_DEPTH + 1);

  state_t state_r, state_nxt;

  // configuration
  logic [PLEN_W-1:0] prog_len_r, prog_len_nxt;

  // run context
  logic [PCW-1:0]      pc_r, pc_nxt;
  logic [BUDGET_W-1:0] steps_r, steps_nxt;
  logic [BUDGET_W-1:0] budget_r, budget_nxt;
  logic [ICW-1:0]      in_idx_r, in_idx_nxt;
  logic [ICW-1:0]      in_len_r, in_len_nxt;

  // bracket search
  logic           dir_fwd_r, dir_fwd_nxt;
  logic [PCW-1:0] scan_r, scan_nxt;
  logic [PCW-1:0] depth_r, depth_nxt;

  // machine status kept across transactions
  logic [OCW-1:0]       fill_r, fill_nxt;
  logic [CONSUME_W-1:0] consumed_r, consumed_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [BUDGET_W-1:0]  last_steps_r, last_steps_nxt;
  logic                 exh_r, exh_nxt;

  // read transaction
  logic              rd_ok_r, rd_ok_nxt;
  logic [BYTE_W-1:0] rbyte_r, rbyte_nxt;

  // output register
  logic                 ov_r, ov_nxt;
  logic [BYTE_W-1:0]    o_rbyte_r;
  logic [OCW-1:0]       o_fill_r;
  logic [CONSUME_W-1:0] o_cons_r;
  logic [BUDGET_W-1:0]  o_steps_r;
  logic                 o_exh_r, o_ovf_r;
  logic                 out_load;

  // ram ports
  logic              prog_we, in_we, out_we;
  logic [PAW-1:0]    prog_raddr;
  logic [BYTE_W-1:0] op, in_rdata, out_rdata;

  // tape ring
  tape_ctrl_t        tctl;
  logic [BYTE_W-1:0] tape_q [TAPE_CELLS];
  logic [BYTE_W-1:0] cell0;

  // handshake and decode
  logic           out_free, acc, cfg_wr;
  logic [PCW-1:0] len_eff;
  logic           run_end, jump_fwd, jump_bwd;
  logic           same_br, opp_br, found, back_end, scan_out;

  assign out_free    = !ov_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  assign acc         = in_ch.valid && in_ch.ready;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == REG_PROGRAM_LENGTH);
  assign cfg_prdata = (cfg_paddr == REG_PROGRAM_LENGTH) ? CFG_DW'(prog_len_r) : '0;

  // program lengths beyond the memory act as the memory size
  assign len_eff = (32'(prog_len_r) > PROGRAM_DEPTH) ? PCW'(PROGRAM_DEPTH) : PCW'(prog_len_r);

  assign cell0    = tape_q[0];
  assign run_end  = (pc_r >= len_eff) || (steps_r >= budget_r);
  assign jump_fwd = (op == OP_OPEN) && (cell0 == '0);
  // a closing bracket at the first position can have no partner
  assign jump_bwd = (op == OP_CLOSE) && (cell0 != '0) && (pc_r != '0);

  // bracket search: same-kind brackets nest deeper, the opposite kind at depth
  // zero is the partner
  assign same_br  = dir_fwd_r ? (op == OP_OPEN) : (op == OP_CLOSE);
  assign opp_br   = dir_fwd_r ? (op == OP_CLOSE) : (op == OP_OPEN);
  assign found    = opp_br && (depth_r == '0);
  assign back_end = !dir_fwd_r && (scan_r == '0);
  assign scan_out = dir_fwd_r && (scan_r >= len_eff);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_ch.kind == KIND_RUN) begin
            state_nxt = ST_FETCH;
          end else if (in_ch.kind == KIND_READ) begin
            state_nxt = ST_OUT_RD;
          end
        end
      end
      ST_FETCH:    state_nxt = run_end ? ST_DONE : ST_EXEC;
      ST_EXEC:     state_nxt = (jump_fwd || jump_bwd) ? ST_SCAN_RD : ST_FETCH;
      ST_SCAN_RD:  state_nxt = scan_out ? ST_FETCH : ST_SCAN_CHK;
      ST_SCAN_CHK: state_nxt = (found || back_end) ? ST_FETCH : ST_SCAN_RD;
      ST_OUT_RD:   state_nxt = ST_DONE;
      ST_DONE:     state_nxt = out_free ? ST_IDLE : ST_DONE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    prog_len_nxt   = cfg_wr ? cfg_pwdata[PLEN_W-1:0] : prog_len_r;
    pc_nxt         = pc_r;
    steps_nxt      = steps_r;
    budget_nxt     = budget_r;
    in_idx_nxt     = in_idx_r;
    in_len_nxt     = in_len_r;
    dir_fwd_nxt    = dir_fwd_r;
    scan_nxt       = scan_r;
    depth_nxt      = depth_r;
    fill_nxt       = fill_r;
    consumed_nxt   = consumed_r;
    ovf_nxt        = ovf_r;
    last_steps_nxt = last_steps_r;
    exh_nxt        = exh_r;
    rd_ok_nxt      = rd_ok_r;
    rbyte_nxt      = rbyte_r;
    out_load       = 1'b0;
    prog_we        = 1'b0;
    in_we          = 1'b0;
    out_we         = 1'b0;
    prog_raddr     = pc_r[PAW-1:0];
    tctl           = '{clr: 1'b0, up: 1'b0, dn: 1'b0, wr: 1'b0, wdata: '0};

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_ch.kind)
            KIND_LOAD_PROG: begin
              prog_we  = 32'(in_ch.address) < PROGRAM_DEPTH;
              out_load = 1'b1;
            end
            KIND_LOAD_IN: begin
              in_we    = 32'(in_ch.address) < INPUT_DEPTH;
              out_load = 1'b1;
            end
            KIND_RUN: begin
              pc_nxt     = '0;
              steps_nxt  = '0;
              in_idx_nxt = '0;
              budget_nxt = in_ch.step_budget;
              in_len_nxt = (32'(in_ch.input_length) > INPUT_DEPTH) ?
                           ICW'(INPUT_DEPTH) : ICW'(in_ch.input_length);
              rbyte_nxt  = '0;
            end
            KIND_READ: begin
              // the output ram is read at the transaction address every cycle
              rd_ok_nxt = 32'(in_ch.address) < 32'(fill_r);
            end
            KIND_CLEAR: begin
              tctl.clr       = 1'b1;
              fill_nxt       = '0;
              consumed_nxt   = '0;
              ovf_nxt        = 1'b0;
              last_steps_nxt = '0;
              exh_nxt        = 1'b0;
              out_load       = 1'b1;
            end
            default: out_load = 1'b1;
          endcase
        end
      end

      ST_FETCH: begin
        // program and input rams read here, data used in exec
        if (run_end) begin
          last_steps_nxt = steps_r;
          exh_nxt        = pc_r < len_eff;
        end
      end

      ST_EXEC: begin
        steps_nxt = steps_r + 24'd1;
        pc_nxt    = pc_r + PCW'(1);
        case (op)
          OP_INC: begin
            tctl.wr    = 1'b1;
            tctl.wdata = cell0 + 8'd1;
          end
          OP_DEC: begin
            tctl.wr    = 1'b1;
            tctl.wdata = cell0 - 8'd1;
          end
          OP_RIGHT: tctl.up = 1'b1;
          OP_LEFT:  tctl.dn = 1'b1;
          OP_OUT: begin
            if (32'(fill_r) < OUTPUT_DEPTH) begin
              out_we   = 1'b1;
              fill_nxt = fill_r + OCW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          OP_IN: begin
            if (consumed_r != CONSUME_MAX) begin
              consumed_nxt = consumed_r + 16'd1;
            end
            tctl.wr = 1'b1;
            if (in_idx_r < in_len_r) begin
              tctl.wdata = in_rdata;
              in_idx_nxt = in_idx_r + ICW'(1);
            end else begin
              tctl.wdata = IN_EOF;
            end
          end
          OP_OPEN: begin
            if (jump_fwd) begin
              pc_nxt      = pc_r;
              dir_fwd_nxt = 1'b1;
              scan_nxt    = pc_r + PCW'(1);
              depth_nxt   = '0;
            end
          end
          OP_CLOSE: begin
            if (jump_bwd) begin
              pc_nxt      = pc_r;
              dir_fwd_nxt = 1'b0;
              scan_nxt    = pc_r - PCW'(1);
              depth_nxt   = '0;
            end
          end
          default: ;
        endcase
      end

      ST_SCAN_RD: begin
        prog_raddr = scan_r[PAW-1:0];
        // ran off the program end: unmatched, fall through
        if (scan_out) begin
          pc_nxt = pc_r + PCW'(1);
        end
      end

      ST_SCAN_CHK: begin
        if (found) begin
          pc_nxt = scan_r + PCW'(1);
        end else begin
          if (same_br) begin
            depth_nxt = depth_r + PCW'(1);
          end else if (opp_br) begin
            depth_nxt = depth_r - PCW'(1);
          end
          if (back_end) begin
            pc_nxt = pc_r + PCW'(1);
          end else begin
            scan_nxt = dir_fwd_r ? scan_r + PCW'(1) : scan_r - PCW'(1);
          end
        end
      end

      ST_OUT_RD: rbyte_nxt = rd_ok_r ? out_rdata : '0;

      ST_DONE:   out_load = out_free;

      default: ;
    endcase
  end

  assign ov_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : ov_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      prog_len_r   <= '0;
      fill_r       <= '0;
      consumed_r   <= '0;
      ovf_r        <= 1'b0;
      last_steps_r <= '0;
      exh_r        <= 1'b0;
      ov_r         <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      prog_len_r   <= prog_len_nxt;
      fill_r       <= fill_nxt;
      consumed_r   <= consumed_nxt;
      ovf_r        <= ovf_nxt;
      last_steps_r <= last_steps_nxt;
      exh_r        <= exh_nxt;
      ov_r         <= ov_nxt;
    end
  end

  // run context and status payload need no reset
  always_ff @(posedge clk) begin
    pc_r      <= pc_nxt;
    steps_r   <= steps_nxt;
    budget_r  <= budget_nxt;
    in_idx_r  <= in_idx_nxt;
    in_len_r  <= in_len_nxt;
    dir_fwd_r <= dir_fwd_nxt;
    scan_r    <= scan_nxt;
    depth_r   <= depth_nxt;
    rd_ok_r   <= rd_ok_nxt;
    rbyte_r   <= rbyte_nxt;
    if (out_load) begin
      // status after this transaction's own update
      o_rbyte_r <= (state_r == ST_IDLE) ? '0 : rbyte_r;
      o_fill_r  <= fill_nxt;
      o_cons_r  <= consumed_nxt;
      o_steps_r <= last_steps_nxt;
      o_exh_r   <= exh_nxt;
      o_ovf_r   <= ovf_nxt;
    end
  end

  assign out_ch.valid            = ov_r;
  assign out_ch.read_byte        = o_rbyte_r;
  assign out_ch.output_count     = COUNT_W'(o_fill_r);
  assign out_ch.inputs_consumed  = o_cons_r;
  assign out_ch.steps_used       = o_steps_r;
  assign out_ch.budget_exhausted = o_exh_r;
  assign out_ch.output_overflow  = o_ovf_r;

  // program store
  bfi_ram #(.WIDTH(BYTE_W), .DEPTH(PROGRAM_DEPTH)) u_prog_ram (
    .clk   (clk),
    .we    (prog_we),
    .waddr (PAW'(32'(in_ch.address))),
    .wdata (in_ch.data),
    .raddr (prog_raddr),
    .rdata (op)
  );

  // input store, read at the per-run input index
  bfi_ram #(.WIDTH(BYTE_W), .DEPTH(INPUT_DEPTH)) u_in_ram (
    .clk   (clk),
    .we    (in_we),
    .waddr (IAW'(32'(in_ch.address))),
    .wdata (in_ch.data),
    .raddr (IAW'(in_idx_r)),
    .rdata (in_rdata)
  );

  // output store, appended at the fill count
  bfi_ram #(.WIDTH(BYTE_W), .DEPTH(OUTPUT_DEPTH)) u_out_ram (
    .clk   (clk),
    .we    (out_we),
    .waddr (OAW'(fill_r)),
    .wdata (cell0),
    .raddr (OAW'(32'(in_ch.address))),
    .rdata (out_rdata)
  );

  // tape ring: cell 0 is under the head, only it takes the write data
  for (genvar i = 0; i < TAPE_CELLS; i++) begin : g_tape
    localparam int UP = (i + 1) % TAPE_CELLS;
    localparam int DN = (i + TAPE_CELLS - 1) % TAPE_CELLS;
    tape_ctrl_t cctl;

    assign cctl = '{clr: tctl.clr, up: tctl.up, dn: tctl.dn,
                    wr: tctl.wr && (i == 0), wdata: tctl.wdata};

    bfi_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (cctl),
      .from_up (tape_q[UP]),
      .from_dn (tape_q[DN]),
      .data_o  (tape_q[i])
    );
  end

endmodule
